@@ rtl/hfs_pkg.sv @@
// Shared types, codes and helpers for the HLL flux solver.
`default_nettype none
package hfs_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SPD,
    ST_AB,
    ST_SEL,
    ST_ML,
    ST_MR,
    ST_PRE,
    ST_FL,
    ST_FR,
    ST_PADD,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_SUM,
    ST_DIV,
    ST_WB,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SPD,
    OP_AB,
    OP_ML,
    OP_MR,
    OP_PRE,
    OP_FL,
    OP_FR,
    OP_PADD,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_SUM,
    OP_DIV,
    OP_WB,
    OP_OUT
  } op_t;

  // Flux slots: density, three momentum components, energy.
  localparam logic [2:0] FLUX_DENS  = 3'd0;
  localparam logic [2:0] FLUX_MOM_X = 3'd1;
  localparam logic [2:0] FLUX_MOM_Z = 3'd3;
  localparam logic [2:0] FLUX_EN    = 3'd4;
  localparam logic [2:0] FLUX_CNT   = 3'd5;

  localparam logic CFG_NUM_DIMS    = 1'b0;
  localparam logic CFG_NORMAL_AXIS = 1'b1;

  typedef struct packed {
    op_t        op;
    logic [2:0] k;
    logic       cap_left;
    logic       cap_right;
  } hfs_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic skip;
    logic div_done;
  } hfs_stat_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hfs_ctrl.sv @@
// Sequencing state machine for the HLL flux solver.
`default_nettype none
module hfs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_side,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output logic                  out_valid,
  input  wire hfs_pkg::hfs_stat_t stat,
  output hfs_pkg::hfs_cmd_t     cmd
);

  hfs_pkg::state_t state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic left_valid_r, left_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic is_mom;

  assign is_mom = (k_r >= hfs_pkg::FLUX_MOM_X) && (k_r <= hfs_pkg::FLUX_MOM_Z);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hfs_pkg::ST_IDLE;
      k_r          <= hfs_pkg::FLUX_DENS;
      left_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      left_valid_r <= left_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    left_valid_nxt = left_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    cmd.op         = hfs_pkg::OP_NONE;
    cmd.k          = k_r;
    cmd.cap_left   = 1'b0;
    cmd.cap_right  = 1'b0;
    case (state_r)
      hfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_side) begin
            cmd.cap_left   = 1'b1;
            left_valid_nxt = 1'b1;
          end else if (left_valid_r) begin
            cmd.cap_right  = 1'b1;
            left_valid_nxt = 1'b0;
            state_nxt      = hfs_pkg::ST_SPD;
          end
        end
      end
      hfs_pkg::ST_SPD: begin
        cmd.op    = hfs_pkg::OP_SPD;
        k_nxt     = hfs_pkg::FLUX_DENS;
        state_nxt = hfs_pkg::ST_AB;
      end
      hfs_pkg::ST_AB: begin
        if (stat.den_zero) begin
          state_nxt = hfs_pkg::ST_OUT;
        end else begin
          cmd.op    = hfs_pkg::OP_AB;
          state_nxt = hfs_pkg::ST_SEL;
        end
      end
      hfs_pkg::ST_SEL: begin
        if (k_r == hfs_pkg::FLUX_CNT) state_nxt = hfs_pkg::ST_OUT;
        else if (stat.skip) k_nxt = k_r + 3'd1;
        else if (is_mom) state_nxt = hfs_pkg::ST_ML;
        else state_nxt = hfs_pkg::ST_PRE;
      end
      hfs_pkg::ST_ML: begin
        cmd.op    = hfs_pkg::OP_ML;
        state_nxt = hfs_pkg::ST_MR;
      end
      hfs_pkg::ST_MR: begin
        cmd.op    = hfs_pkg::OP_MR;
        state_nxt = hfs_pkg::ST_FL;
      end
      hfs_pkg::ST_PRE: begin
        cmd.op    = hfs_pkg::OP_PRE;
        state_nxt = hfs_pkg::ST_FL;
      end
      hfs_pkg::ST_FL: begin
        cmd.op    = hfs_pkg::OP_FL;
        state_nxt = hfs_pkg::ST_FR;
      end
      hfs_pkg::ST_FR: begin
        cmd.op    = hfs_pkg::OP_FR;
        state_nxt = hfs_pkg::ST_PADD;
      end
      hfs_pkg::ST_PADD: begin
        cmd.op    = hfs_pkg::OP_PADD;
        state_nxt = hfs_pkg::ST_T1;
      end
      hfs_pkg::ST_T1: begin
        cmd.op    = hfs_pkg::OP_T1;
        state_nxt = hfs_pkg::ST_T2;
      end
      hfs_pkg::ST_T2: begin
        cmd.op    = hfs_pkg::OP_T2;
        state_nxt = hfs_pkg::ST_T3;
      end
      hfs_pkg::ST_T3: begin
        cmd.op    = hfs_pkg::OP_T3;
        state_nxt = hfs_pkg::ST_SUM;
      end
      hfs_pkg::ST_SUM: begin
        cmd.op    = hfs_pkg::OP_SUM;
        state_nxt = hfs_pkg::ST_DIV;
      end
      hfs_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = hfs_pkg::ST_WB;
        else cmd.op = hfs_pkg::OP_DIV;
      end
      hfs_pkg::ST_WB: begin
        cmd.op    = hfs_pkg::OP_WB;
        k_nxt     = k_r + 3'd1;
        state_nxt = hfs_pkg::ST_SEL;
      end
      hfs_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = hfs_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = hfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hfs_pkg::ST_IDLE;
    endcase
  end

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_side && left_valid_r)
      |=> (state_r == hfs_pkg::ST_SPD) && !left_valid_r)
    else $error("right transfer with held left did not start a solve");

  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == hfs_pkg::ST_OUT)
    else $error("result appeared outside the output step");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hfs_pkg::ST_DIV) |-> !in_ready)
    else $error("input taken during a division");

  a_left: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_side) |=> left_valid_r)
    else $error("left transfer not held");

endmodule
`default_nettype wire

@@ rtl/hfs_dp.sv @@
// Datapath of the HLL flux solver: state registers, shared multiplier and divider.
`default_nettype none
module hfs_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [1:0]          cfg_data,
  input  wire logic signed [31:0]  in_density,
  input  wire logic signed [31:0]  in_vel_x,
  input  wire logic signed [31:0]  in_vel_y,
  input  wire logic signed [31:0]  in_vel_z,
  input  wire logic signed [31:0]  in_pressure,
  input  wire logic signed [31:0]  in_total_energy,
  input  wire logic [30:0]         in_sound_speed,
  input  wire hfs_pkg::hfs_cmd_t   cmd,
  output hfs_pkg::hfs_stat_t       stat,
  output logic signed [31:0]       out_flux_density,
  output logic signed [31:0]       out_flux_mom_x,
  output logic signed [31:0]       out_flux_mom_y,
  output logic signed [31:0]       out_flux_mom_z,
  output logic signed [31:0]       out_flux_energy,
  output logic                     out_degenerate
);

  localparam int NW = 34 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] QMAX = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] QMIN = NW'(64'h8000_0000);

  logic [1:0] num_dims_r, normal_axis_r;

  logic signed [31:0] l_d_r, l_vx_r, l_vy_r, l_vz_r, l_p_r, l_e_r;
  logic signed [31:0] r_d_r, r_vx_r, r_vy_r, r_vz_r, r_p_r, r_e_r;
  logic [30:0] l_c_r, r_c_r;

  logic signed [31:0] al_r, ar_r, ab_r, xl_r, xr_r, fl_r, fr_r, du_r;
  logic [32:0] den_r;
  logic [33:0] rem_r;
  logic [NW-1:0] quo_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;
  logic signed [31:0] res_r [5];

  logic [1:0] n, ax;
  logic signed [31:0] vln, vrn, l_ax, r_ax;
  logic signed [33:0] a1, a2, b1, b2, al_w, ar_w;
  logic signed [31:0] al_c, ar_c;
  logic signed [31:0] mul_a, mul_b, prod;
  logic signed [63:0] prod_full;
  logic signed [33:0] num;
  logic [33:0] mag, sh;
  logic signed [31:0] qsat;

  function automatic logic signed [31:0] sel3(input logic [1:0] i,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] c);
    logic signed [31:0] r;
    case (i)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] maxz(input logic signed [33:0] x,
      input logic signed [33:0] y);
    logic signed [33:0] m;
    m = (x > y) ? x : y;
    return (m < 34'sd0) ? 34'sd0 : m;
  endfunction

  assign n    = (normal_axis_r == 2'd3) ? 2'd2 : normal_axis_r;
  assign ax   = 2'(cmd.k - 3'd1);
  assign vln  = sel3(n, l_vx_r, l_vy_r, l_vz_r);
  assign vrn  = sel3(n, r_vx_r, r_vy_r, r_vz_r);
  assign l_ax = sel3(ax, l_vx_r, l_vy_r, l_vz_r);
  assign r_ax = sel3(ax, r_vx_r, r_vy_r, r_vz_r);

  // Candidate wave speeds, widened so that no difference wraps.
  assign a1   = 34'(signed'({1'b0, l_c_r})) - 34'(vln);
  assign a2   = 34'(signed'({1'b0, r_c_r})) - 34'(vrn);
  assign b1   = 34'(vrn) + 34'(signed'({1'b0, r_c_r}));
  assign b2   = 34'(vln) + 34'(signed'({1'b0, l_c_r}));
  assign al_w = maxz(a1, a2);
  assign ar_w = maxz(b1, b2);
  assign al_c = hfs_pkg::sat64(64'(al_w));
  assign ar_c = hfs_pkg::sat64(64'(ar_w));

  always_comb begin
    case (cmd.op)
      hfs_pkg::OP_AB: begin mul_a = al_r; mul_b = ar_r; end
      hfs_pkg::OP_ML: begin mul_a = l_d_r; mul_b = l_ax; end
      hfs_pkg::OP_MR: begin mul_a = r_d_r; mul_b = r_ax; end
      hfs_pkg::OP_FL: begin mul_a = xl_r; mul_b = vln; end
      hfs_pkg::OP_FR: begin mul_a = xr_r; mul_b = vrn; end
      hfs_pkg::OP_T1: begin mul_a = ar_r; mul_b = fl_r; end
      hfs_pkg::OP_T2: begin mul_a = al_r; mul_b = fr_r; end
      hfs_pkg::OP_T3: begin mul_a = ab_r; mul_b = du_r; end
      default:        begin mul_a = al_r; mul_b = ar_r; end
    endcase
  end

  // Shared multiplier; the arithmetic shift rounds toward minus infinity.
  assign prod_full = mul_a * mul_b;
  assign prod      = hfs_pkg::sat64(prod_full >>> FRAC_BITS);

  assign num = 34'(fl_r) + 34'(fr_r) - 34'(du_r);
  assign mag = (num < 34'sd0) ? 34'(-num) : 34'(num);
  assign sh  = {rem_r[32:0], quo_r[NW-1]};

  always_comb begin
    if (neg_r) qsat = (quo_r > QMIN) ? 32'sh8000_0000 : 32'(-quo_r[31:0]);
    else qsat = (quo_r > QMAX) ? 32'sh7FFF_FFFF : quo_r[31:0];
  end

  assign stat.den_zero = (den_r == 33'd0);
  assign stat.skip = (cmd.k >= hfs_pkg::FLUX_MOM_X) && (cmd.k <= hfs_pkg::FLUX_MOM_Z)
                     && (ax >= num_dims_r);
  assign stat.div_done = (cnt_r == CW'(NW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r    <= 2'd1;
      normal_axis_r <= 2'd0;
    end else if (cfg_we) begin
      if (cfg_index == hfs_pkg::CFG_NUM_DIMS) num_dims_r <= cfg_data;
      else normal_axis_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_left) begin
      l_d_r <= in_density;  l_vx_r <= in_vel_x; l_vy_r <= in_vel_y;
      l_vz_r <= in_vel_z;   l_p_r <= in_pressure; l_e_r <= in_total_energy;
      l_c_r <= in_sound_speed;
    end
    if (cmd.cap_right) begin
      r_d_r <= in_density;  r_vx_r <= in_vel_x; r_vy_r <= in_vel_y;
      r_vz_r <= in_vel_z;   r_p_r <= in_pressure; r_e_r <= in_total_energy;
      r_c_r <= in_sound_speed;
    end
    case (cmd.op)
      hfs_pkg::OP_SPD: begin
        al_r  <= al_c;
        ar_r  <= ar_c;
        den_r <= 33'(al_c[30:0]) + 33'(ar_c[30:0]);
        for (int i = 0; i < 5; i++) res_r[i] <= 32'sd0;
      end
      hfs_pkg::OP_AB: ab_r <= prod;
      hfs_pkg::OP_ML: xl_r <= prod;
      hfs_pkg::OP_MR: xr_r <= prod;
      hfs_pkg::OP_PRE: begin
        if (cmd.k == hfs_pkg::FLUX_EN) begin
          xl_r <= hfs_pkg::sat64(64'(l_e_r) + 64'(l_p_r));
          xr_r <= hfs_pkg::sat64(64'(r_e_r) + 64'(r_p_r));
        end else begin
          xl_r <= l_d_r;
          xr_r <= r_d_r;
        end
      end
      hfs_pkg::OP_FL: begin
        fl_r <= prod;
        if (cmd.k == hfs_pkg::FLUX_EN) du_r <= hfs_pkg::sat64(64'(r_e_r) - 64'(l_e_r));
        else du_r <= hfs_pkg::sat64(64'(xr_r) - 64'(xl_r));
      end
      hfs_pkg::OP_FR: fr_r <= prod;
      hfs_pkg::OP_PADD: begin
        // Pressure only enters the momentum component along the normal.
        if (cmd.k != hfs_pkg::FLUX_DENS && cmd.k != hfs_pkg::FLUX_EN && ax == n) begin
          fl_r <= hfs_pkg::sat64(64'(fl_r) + 64'(l_p_r));
          fr_r <= hfs_pkg::sat64(64'(fr_r) + 64'(r_p_r));
        end
      end
      hfs_pkg::OP_T1: fl_r <= prod;
      hfs_pkg::OP_T2: fr_r <= prod;
      hfs_pkg::OP_T3: du_r <= prod;
      hfs_pkg::OP_SUM: begin
        neg_r <= (num < 34'sd0);
        quo_r <= {mag, {FRAC_BITS{1'b0}}};
        rem_r <= 34'd0;
        cnt_r <= '0;
      end
      hfs_pkg::OP_DIV: begin
        if (sh >= {1'b0, den_r}) begin
          rem_r <= sh - {1'b0, den_r};
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CW'(1);
      end
      hfs_pkg::OP_WB: res_r[cmd.k] <= qsat;
      hfs_pkg::OP_OUT: begin
        out_flux_density <= res_r[0];
        out_flux_mom_x   <= res_r[1];
        out_flux_mom_y   <= res_r[2];
        out_flux_mom_z   <= res_r[3];
        out_flux_energy  <= res_r[4];
        out_degenerate   <= stat.den_zero;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/hll_flux_solver.sv @@
// A left transfer is held in the left registers; a right transfer starts a solve whose
// result time is set by the shared restoring divider (FRAC_BITS + 34 steps per flux) and
// one multiplier; a momentum component at or above num_dims skips the multiplier and divider.
// A degenerate face (zero speed sum) goes straight to the output. The block takes one right
// item at a time; the output register lets the next item in early.
// Reset (synchronous, active low) clears the held left state flag, the sequencer and config.
`default_nettype none
module hll_flux_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [1:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_side,
  input  wire logic signed [31:0] in_density,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_vel_z,
  input  wire logic signed [31:0] in_pressure,
  input  wire logic signed [31:0] in_total_energy,
  input  wire logic [30:0]        in_sound_speed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_flux_density,
  output logic signed [31:0]      out_flux_mom_x,
  output logic signed [31:0]      out_flux_mom_y,
  output logic signed [31:0]      out_flux_mom_z,
  output logic signed [31:0]      out_flux_energy,
  output logic                    out_degenerate
);

  hfs_pkg::hfs_cmd_t  cmd;
  hfs_pkg::hfs_stat_t stat;

  hfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_side   (in_side),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  hfs_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_density       (in_density),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_vel_z         (in_vel_z),
    .in_pressure      (in_pressure),
    .in_total_energy  (in_total_energy),
    .in_sound_speed   (in_sound_speed),
    .cmd              (cmd),
    .stat             (stat),
    .out_flux_density (out_flux_density),
    .out_flux_mom_x   (out_flux_mom_x),
    .out_flux_mom_y   (out_flux_mom_y),
    .out_flux_mom_z   (out_flux_mom_z),
    .out_flux_energy  (out_flux_energy),
    .out_degenerate   (out_degenerate)
  );

endmodule
`default_nettype wire

@@ tb/hll_flux_solver_tb.sv @@
// Self-checking testbench for the HLL flux solver: directed table, then random face pairs.
module hll_flux_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic               side;
    logic signed [31:0] dens;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] pres;
    logic signed [31:0] en;
    logic [30:0]        cs;
  } face_item_t;

  typedef struct {
    logic signed [31:0] fd;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] fe;
    logic               dg;
  } flux_t;

  typedef struct {
    face_item_t it;
    bit         typed;
    flux_t      want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [1:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_side = 0;
  logic signed [31:0] in_density = 0, in_vel_x = 0, in_vel_y = 0, in_vel_z = 0;
  logic signed [31:0] in_pressure = 0, in_total_energy = 0;
  logic [30:0] in_sound_speed = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_flux_density, out_flux_mom_x, out_flux_mom_y, out_flux_mom_z;
  logic signed [31:0] out_flux_energy;
  logic out_degenerate;

  hll_flux_solver dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state.
  longint held_l[7];
  bit held_ok = 0;
  logic [1:0] p_dims = 1;
  logic [1:0] p_axis = 0;

  flux_t expected_fluxes[$];
  int errors = 0;
  int checked = 0;
  int degen_seen = 0;
  int send_idle_pct = 12;
  int recv_stall_pct = 62;

  function automatic longint sat32f(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Arithmetic shift on a signed 64-bit value rounds toward minus infinity.
  function automatic longint qm(longint a, longint b);
    return sat32f((a * b) >>> FRAC);
  endfunction

  function automatic longint hll_mix(longint ar, longint al, longint ab, longint fl,
                                     longint fr, longint du, longint den);
    longint num;
    num = qm(ar, fl) + qm(al, fr) - qm(ab, du);
    return sat32f((num * (longint'(1) << FRAC)) / den);
  endfunction

  function automatic longint mx3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Updates the predictor with one accepted item; returns 1 when a result is due.
  function automatic bit solve_face(face_item_t it, output flux_t f);
    longint r[7];
    longint res[5];
    longint al, ar, ab, den, vln, vrn, ml, mr, fl, fr;
    int n;
    r[0] = it.dens; r[1] = it.vx; r[2] = it.vy; r[3] = it.vz;
    r[4] = it.pres; r[5] = it.en; r[6] = longint'({1'b0, it.cs});
    f = '{default: 0};
    if (!it.side) begin
      held_l = r;
      held_ok = 1;
      return 0;
    end
    if (!held_ok) return 0;
    held_ok = 0;
    n = (p_axis > 2) ? 2 : p_axis;
    al = sat32f(mx3(0, held_l[6] - held_l[1+n], r[6] - r[1+n]));
    ar = sat32f(mx3(0, r[1+n] + r[6], held_l[1+n] + held_l[6]));
    den = al + ar;
    for (int i = 0; i < 5; i++) res[i] = 0;
    if (den != 0) begin
      vln = held_l[1+n];
      vrn = r[1+n];
      ab = qm(al, ar);
      res[0] = hll_mix(ar, al, ab, qm(held_l[0], vln), qm(r[0], vrn),
                       sat32f(r[0] - held_l[0]), den);
      for (int ax = 0; ax < 3; ax++) begin
        if (ax < p_dims) begin
          ml = qm(held_l[0], held_l[1+ax]);
          mr = qm(r[0], r[1+ax]);
          fl = qm(ml, vln);
          fr = qm(mr, vrn);
          if (ax == n) begin
            fl = sat32f(fl + held_l[4]);
            fr = sat32f(fr + r[4]);
          end
          res[1+ax] = hll_mix(ar, al, ab, fl, fr, sat32f(mr - ml), den);
        end
      end
      res[4] = hll_mix(ar, al, ab, qm(sat32f(held_l[5] + held_l[4]), vln),
                       qm(sat32f(r[5] + r[4]), vrn), sat32f(r[5] - held_l[5]), den);
    end
    f.fd = res[0][31:0];
    f.mx = res[1][31:0];
    f.my = res[2][31:0];
    f.mz = res[3][31:0];
    f.fe = res[4][31:0];
    f.dg = (den == 0);
    return 1;
  endfunction

  function automatic face_item_t mk(logic side, logic [31:0] d, logic [31:0] vx,
                                    logic [31:0] vy, logic [31:0] vz, logic [31:0] p,
                                    logic [31:0] e, logic [30:0] c);
    face_item_t it;
    it.side = side; it.dens = d; it.vx = vx; it.vy = vy; it.vz = vz;
    it.pres = p; it.en = e; it.cs = c;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic face_item_t rand_item(logic side);
    logic [30:0] c;
    c = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0010_0000));
    return mk(side, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), c);
  endfunction

  task automatic push_item(face_item_t it, bit typed, flux_t want);
    flux_t f;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct + 20) @(posedge clk);
    end
    in_valid <= 1;
    in_side <= it.side;
    in_density <= it.dens;
    in_vel_x <= it.vx;
    in_vel_y <= it.vy;
    in_vel_z <= it.vz;
    in_pressure <= it.pres;
    in_total_energy <= it.en;
    in_sound_speed <= it.cs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (solve_face(it, f)) expected_fluxes.push_back(typed ? want : f);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (expected_fluxes.size() > 0) @(posedge clk);
    // Left and ignored right items give no result, so allow the block to settle.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] dims, logic [1:0] axis);
    cfg_we <= 1;
    cfg_index <= hfs_pkg::CFG_NUM_DIMS;
    cfg_data <= dims;
    @(posedge clk);
    p_dims = dims;
    cfg_index <= hfs_pkg::CFG_NORMAL_AXIS;
    cfg_data <= axis;
    @(posedge clk);
    p_axis = axis;
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
    end
  endtask

  // Result side: check every transfer, then choose the next ready level.
  always @(posedge clk) begin
    flux_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fluxes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h %h %h %h %h %b", $time,
                 out_flux_density, out_flux_mom_x, out_flux_mom_y, out_flux_mom_z,
                 out_flux_energy, out_degenerate);
      end else begin
        w = expected_fluxes.pop_front();
        checked++;
        if (out_degenerate) degen_seen++;
        check_field("flux_density", w.fd, out_flux_density);
        check_field("flux_mom_x", w.mx, out_flux_mom_x);
        check_field("flux_mom_y", w.my, out_flux_mom_y);
        check_field("flux_mom_z", w.mz, out_flux_mom_z);
        check_field("flux_energy", w.fe, out_flux_energy);
        check_field("degenerate", 32'(w.dg), 32'(out_degenerate));
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #6000000;
    $display("FAIL hll_flux_solver");
    $finish;
  end

  initial begin
    row_t rows[$];
    flux_t zero_f;
    flux_t degen_f;
    logic [1:0] dims_set[7] = '{1, 3, 2, 0, 3, 2, 1};
    logic [1:0] axis_set[7] = '{0, 2, 1, 0, 3, 2, 2};
    int items = 0;

    zero_f = '{default: 0};
    degen_f = '{default: 0};
    degen_f.dg = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // A right item with nothing held is ignored; all-zero faces are degenerate.
    rows.push_back('{mk(1, 32'h0001_0000, 0, 0, 0, 0, 0, 31'h1_0000), 0, zero_f});
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 0, zero_f});
    rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0), 1, degen_f});
    rows.push_back('{mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF), 0, zero_f});
    rows.push_back('{mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF), 0, zero_f});
    rows.push_back('{mk(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 0), 0, zero_f});
    rows.push_back('{mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, zero_f});
    // A second left item replaces the first one; the right item consumes it.
    rows.push_back('{mk(0, 32'h0003_0000, 32'hFFFF_0000, 0, 0, 32'h0005_0000,
                        32'h0009_0000, 31'h2_0000), 0, zero_f});
    rows.push_back('{mk(0, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'hFFFE_0000,
                        32'h0001_0000, 32'h0002_8000, 31'h1_2000), 0, zero_f});
    rows.push_back('{mk(1, 32'h0000_2000, 32'h0000_4000, 32'hFFFF_8000, 32'h0003_0000,
                        32'h0000_1000, 32'h0000_3000, 31'h0_E000), 0, zero_f});
    rows.push_back('{mk(1, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 31'h1_0000), 0, zero_f});
    // Zero speeds on both sides with non-zero state are still degenerate.
    rows.push_back('{mk(0, 32'h0004_0000, 0, 32'h0001_0000, 0, 32'h0002_0000,
                        32'h0007_0000, 0), 0, zero_f});
    rows.push_back('{mk(1, 32'h0002_0000, 0, 32'hFFFF_0000, 0, 32'h0003_0000,
                        32'h0001_0000, 0), 1, degen_f});
    rows.push_back('{mk(0, 32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0001_0000,
                        32'h0002_0000, 31'h1_0000), 0, zero_f});
    rows.push_back('{mk(1, 32'h0000_C000, 32'hFFFF_C000, 0, 0, 32'h0000_8000,
                        32'h0001_8000, 31'h0_C000), 0, zero_f});

    foreach (rows[i]) push_item(rows[i].it, rows[i].typed, rows[i].want);
    items = rows.size();
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 62;
        recv_stall_pct = 12;
      end else if (ph == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_cfg(dims_set[ph], axis_set[ph]);
      for (int k = 0; k < 42; k++) begin
        case ($urandom_range(9))
          0: begin
            push_item(rand_item(1), 0, zero_f);
            items++;
          end
          1: begin
            push_item(rand_item(0), 0, zero_f);
            push_item(rand_item(0), 0, zero_f);
            push_item(rand_item(1), 0, zero_f);
            items += 3;
          end
          default: begin
            push_item(rand_item(0), 0, zero_f);
            push_item(rand_item(1), 0, zero_f);
            items += 2;
          end
        endcase
      end
      wait_drained();
    end

    $display("Sent %0d items over 7 dimension/axis settings; %0d results checked, %0d degenerate.",
             items, checked, degen_seen);
    if (errors == 0) begin
      $display("PASS hll_flux_solver");
    end else begin
      $display("FAIL hll_flux_solver");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/hfs_pkg.sv
rtl/hfs_ctrl.sv
rtl/hfs_dp.sv
rtl/hll_flux_solver.sv
tb/hll_flux_solver_tb.sv
